// ===== rtl/core/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

	// width used for index and count compares, enough for DEPTH up to 64
	localparam int unsigned EW = 7;

	typedef enum logic [2:0] {
		OP_READ     = 3'd0,
		OP_WRITE    = 3'd1,
		OP_INSERT   = 3'd2,
		OP_DELETE   = 3'd3,
		OP_SORT     = 3'd4,
		OP_TRAVERSE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS,
		S_INS_WR,
		S_DEL,
		S_DEL_WR,
		S_SRT_KEY,
		S_SRT_LOAD,
		S_SRT_SCAN,
		S_SRT_TEST,
		S_SRT_PLACE,
		S_TRV_RD,
		S_TRV_OUT,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic [5:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] item;
		logic [1:0]         status;
		logic [5:0]         entry_count;
		logic               last;
	} rsp_t;

	// datapath conditions seen by the sequencer
	typedef struct packed {
		logic       accept;
		logic       out_free;
		logic       err;
		logic [2:0] op;
		logic       sort_short;
		logic       ins_done;
		logic       idx_end;
		logic       j_zero;
		logic       key_gt;
	} flags_t;

endpackage

// ===== rtl/core/positional_list_engine_with_sort.sv =====
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries kept in one single-port-read
// memory, driven by a small sequencer; one request is taken at a time and req_stall
// stays high until its last result has been placed in the output register. Read,
// write, sort of fewer than two entries and every rejected request go straight from
// decode to the reply. Insert and delete shift the entries behind the position, with
// one memory read and one write per moved entry; traverse returns one result per entry.
// Sort is an insertion sort through one signed comparator, shifting each scanned entry
// that is greater than the key up one place before the key is written.
// Results wait in a one-deep output register, and a stalled result holds the engine.
module positional_list_engine_with_sort #(
	parameter int unsigned DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ple_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ple_pkg::rsp_t  rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = ple_pkg::EW;

	ple_pkg::state_t state;
	ple_pkg::flags_t flags;

	logic [31:0]        mem_q [DEPTH];
	logic signed [31:0] rdata_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [31:0]        mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;

	logic [2:0]         op_q;
	logic [5:0]         pos_q;
	logic signed [31:0] val_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [AW-1:0]      j_q;
	logic signed [31:0] key_q;
	logic [1:0]         res_status_q;

	logic               rsp_valid_q;
	ple_pkg::rsp_t      rsp_q;
	logic               rsp_load;
	ple_pkg::rsp_t      rsp_nxt;

	logic [EW-1:0]      pos_e;
	logic [EW-1:0]      count_e;
	logic [EW-1:0]      idx_e;
	logic [CW-1:0]      idx_inc;
	logic [CW-1:0]      idx_dec;
	logic [1:0]         status_dec;
	logic               out_free;

	assign pos_e   = EW'(pos_q);
	assign count_e = EW'(count_q);
	assign idx_e   = EW'(idx_q);
	assign idx_inc = idx_q + CW'(1);
	assign idx_dec = idx_q - CW'(1);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state != ple_pkg::S_IDLE);

	// request checks, evaluated against the stored count
	always_comb begin
		status_dec = ple_pkg::ST_OK;
		case (op_q)
			ple_pkg::OP_READ, ple_pkg::OP_WRITE, ple_pkg::OP_DELETE: begin
				if (count_e == '0)         status_dec = ple_pkg::ST_EMPTY;
				else if (pos_e >= count_e) status_dec = ple_pkg::ST_RANGE;
			end
			ple_pkg::OP_INSERT: begin
				if (pos_e > count_e)                status_dec = ple_pkg::ST_RANGE;
				else if (count_e >= EW'(DEPTH))     status_dec = ple_pkg::ST_FULL;
			end
			ple_pkg::OP_SORT: status_dec = ple_pkg::ST_OK;
			ple_pkg::OP_TRAVERSE: begin
				if (count_e == '0) status_dec = ple_pkg::ST_EMPTY;
			end
			default: status_dec = ple_pkg::ST_RANGE;
		endcase
	end

	always_comb begin
		flags            = '0;
		flags.accept     = req_valid && !req_stall;
		flags.out_free   = out_free;
		flags.err        = (status_dec != ple_pkg::ST_OK);
		flags.op         = op_q;
		flags.sort_short = (count_e < EW'(2));
		flags.ins_done   = (idx_e == pos_e);
		flags.idx_end    = ((idx_e + EW'(1)) >= count_e);
		flags.j_zero     = (j_q == '0);
		// the one shared comparator: scanned entry against the held key
		flags.key_gt     = (rdata_q > key_q);
	end

	ple_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.state  (state)
	);

	// memory strobes and result loading per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = rdata_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		rsp_load  = 1'b0;
		rsp_nxt   = '0;
		case (state)
			ple_pkg::S_DECODE: begin
				if (!flags.err && op_q == ple_pkg::OP_WRITE) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = val_q;
				end
				if (!flags.err && op_q == ple_pkg::OP_READ) begin
					mem_re    = 1'b1;
					mem_raddr = pos_q[AW-1:0];
				end
			end
			ple_pkg::S_INS: begin
				if (flags.ins_done) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = val_q;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_dec[AW-1:0];
				end
			end
			ple_pkg::S_INS_WR, ple_pkg::S_DEL_WR: begin
				mem_we = 1'b1;
			end
			ple_pkg::S_DEL: begin
				mem_re    = !flags.idx_end;
				mem_raddr = idx_inc[AW-1:0];
			end
			ple_pkg::S_SRT_KEY, ple_pkg::S_TRV_RD: begin
				mem_re = 1'b1;
			end
			ple_pkg::S_SRT_SCAN: begin
				mem_re    = !flags.j_zero;
				mem_raddr = j_q - AW'(1);
			end
			ple_pkg::S_SRT_TEST: begin
				mem_we    = flags.key_gt;
				mem_waddr = j_q;
			end
			ple_pkg::S_SRT_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = key_q;
			end
			ple_pkg::S_TRV_OUT: begin
				rsp_load            = out_free;
				rsp_nxt.item        = rdata_q;
				rsp_nxt.status      = ple_pkg::ST_OK;
				rsp_nxt.entry_count = 6'(count_q);
				rsp_nxt.last        = flags.idx_end;
			end
			ple_pkg::S_REPLY: begin
				rsp_load            = out_free;
				rsp_nxt.item        = (op_q == ple_pkg::OP_READ && res_status_q == ple_pkg::ST_OK) ?
				                      rdata_q : '0;
				rsp_nxt.status      = res_status_q;
				rsp_nxt.entry_count = 6'(count_q);
				rsp_nxt.last        = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state == ple_pkg::S_INS && flags.ins_done) begin
			count_q <= count_q + CW'(1);
		end else if (state == ple_pkg::S_DEL && flags.idx_end) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (flags.accept) begin
			op_q  <= req.operation;
			pos_q <= req.position;
			val_q <= req.value;
		end
		case (state)
			ple_pkg::S_DECODE: begin
				res_status_q <= status_dec;
				case (op_q)
					ple_pkg::OP_INSERT: idx_q <= count_q;
					ple_pkg::OP_DELETE: idx_q <= CW'(pos_q);
					ple_pkg::OP_SORT:   idx_q <= CW'(1);
					default:            idx_q <= '0;
				endcase
			end
			ple_pkg::S_INS_WR:   idx_q <= idx_dec;
			ple_pkg::S_DEL_WR:   idx_q <= idx_inc;
			ple_pkg::S_SRT_LOAD: begin
				key_q <= rdata_q;
				j_q   <= idx_q[AW-1:0];
			end
			ple_pkg::S_SRT_TEST: begin
				if (flags.key_gt) j_q <= j_q - AW'(1);
			end
			ple_pkg::S_SRT_PLACE: idx_q <= idx_inc;
			ple_pkg::S_TRV_OUT: begin
				if (out_free) idx_q <= idx_inc;
			end
			default: begin
			end
		endcase
	end

	// one-deep output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= rsp_nxt;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_e <= EW'(DEPTH))
		else $error("entry count beyond depth");

	a_err_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ple_pkg::ST_OK) |-> (rsp.item == '0))
		else $error("flagged result carries data");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		($past(state) == ple_pkg::S_INS || $past(state) == ple_pkg::S_DEL))
		else $error("count changed outside insert or delete");

	a_idle_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ple_pkg::S_IDLE) |-> !rsp_load)
		else $error("result loaded while idle");
`endif

endmodule

// ===== rtl/core/ple_seq.sv =====
`timescale 1ns / 1ps

module ple_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  ple_pkg::flags_t   flags,
	output ple_pkg::state_t   state
);

	ple_pkg::state_t state_q;
	ple_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ple_pkg::S_IDLE: begin
				if (flags.accept) state_nxt = ple_pkg::S_DECODE;
			end
			ple_pkg::S_DECODE: begin
				if (flags.err) begin
					state_nxt = ple_pkg::S_REPLY;
				end else begin
					case (flags.op)
						ple_pkg::OP_INSERT:   state_nxt = ple_pkg::S_INS;
						ple_pkg::OP_DELETE:   state_nxt = ple_pkg::S_DEL;
						ple_pkg::OP_SORT:     state_nxt = flags.sort_short ?
						                                  ple_pkg::S_REPLY : ple_pkg::S_SRT_KEY;
						ple_pkg::OP_TRAVERSE: state_nxt = ple_pkg::S_TRV_RD;
						default:              state_nxt = ple_pkg::S_REPLY;
					endcase
				end
			end
			ple_pkg::S_INS:       state_nxt = flags.ins_done ? ple_pkg::S_REPLY : ple_pkg::S_INS_WR;
			ple_pkg::S_INS_WR:    state_nxt = ple_pkg::S_INS;
			ple_pkg::S_DEL:       state_nxt = flags.idx_end ? ple_pkg::S_REPLY : ple_pkg::S_DEL_WR;
			ple_pkg::S_DEL_WR:    state_nxt = ple_pkg::S_DEL;
			ple_pkg::S_SRT_KEY:   state_nxt = ple_pkg::S_SRT_LOAD;
			ple_pkg::S_SRT_LOAD:  state_nxt = ple_pkg::S_SRT_SCAN;
			ple_pkg::S_SRT_SCAN:  state_nxt = flags.j_zero ? ple_pkg::S_SRT_PLACE : ple_pkg::S_SRT_TEST;
			ple_pkg::S_SRT_TEST:  state_nxt = flags.key_gt ? ple_pkg::S_SRT_SCAN : ple_pkg::S_SRT_PLACE;
			ple_pkg::S_SRT_PLACE: state_nxt = flags.idx_end ? ple_pkg::S_REPLY : ple_pkg::S_SRT_KEY;
			ple_pkg::S_TRV_RD:    state_nxt = ple_pkg::S_TRV_OUT;
			ple_pkg::S_TRV_OUT: begin
				if (flags.out_free) state_nxt = flags.idx_end ? ple_pkg::S_IDLE : ple_pkg::S_TRV_RD;
			end
			ple_pkg::S_REPLY: begin
				if (flags.out_free) state_nxt = ple_pkg::S_IDLE;
			end
			default: state_nxt = ple_pkg::S_IDLE;
		endcase
	end

	assign state = state_q;

endmodule
